// ----- sv/tbeq_pkg.sv -----
// shared types, widths, register codes and reset values of the three-band equalizer
// no dependencies; every other file of the block imports this package

package tbeq_pkg;

    // field and datapath widths
    localparam int SAMPLE_W         = 24;
    localparam int CHAN_W           = 3;
    localparam int COEF_W           = 16;
    localparam int GAIN_W           = 16;
    localparam int STATE_W          = 32;
    localparam int CFG_W            = 64;
    localparam int CFG_IDX_W        = 3;
    localparam int OPA_W            = STATE_W + 1;
    localparam int OPB_W            = GAIN_W + 1;
    localparam int PROD_W           = OPA_W + OPB_W;
    localparam int ACC_W            = 58;
    localparam int NUM_CHANNELS_DEF = 8;

    // rounding positions
    localparam int FILT_SHIFT = 16;
    localparam int BAND_SHIFT = 12;
    localparam int CHAN_SHIFT = 20;
    localparam int HI_SPLIT   = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASS_COEF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TREBLE_COEF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASS_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREBLE_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_LOWER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_UPPER  = 3'd6;

    // register reset values
    localparam logic [COEF_W-1:0] BASS_COEF_RST   = 16'd64907;
    localparam logic [COEF_W-1:0] TREBLE_COEF_RST = 16'd38888;
    localparam logic [GAIN_W-1:0] UNITY_GAIN_RST  = 16'd4096;
    localparam logic [CFG_W-1:0]  CHAN_GAINS_RST  = 64'h1000_1000_1000_1000;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_BASS,
        ST_MUL_TREB,
        ST_MUL_LOW,
        ST_MUL_MID,
        ST_MUL_HIGH,
        ST_SUM,
        ST_MUL_CG_LO,
        ST_MUL_CG_HI,
        ST_CG_SUM,
        ST_FINISH
    } ctrl_state_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_BASS,
        MUL_TREB,
        MUL_LOW,
        MUL_MID,
        MUL_HIGH,
        MUL_CG_LO,
        MUL_CG_HI
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_BAND,
        ACC_ADD,
        ACC_LOAD_CHAN,
        ACC_ADD_HIGH
    } acc_op_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     upd_bass;
        logic     upd_treb;
        acc_op_t  acc_op;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- sv/tbeq_ctrl.sv -----
// sequencer of the equalizer: steps one word through the shared multiplier schedule
// depends on tbeq_pkg (state enum, command and status structs)

module tbeq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tbeq_pkg::dp_status_t status,
    output tbeq_pkg::dp_cmd_t    cmd
);
    import tbeq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_BASS;
                end
            end
            ST_MUL_BASS:  state_next = status.bypass ? ST_FINISH : ST_MUL_TREB;
            ST_MUL_TREB:  state_next = ST_MUL_LOW;
            ST_MUL_LOW:   state_next = ST_MUL_MID;
            ST_MUL_MID:   state_next = ST_MUL_HIGH;
            ST_MUL_HIGH:  state_next = ST_SUM;
            ST_SUM:       state_next = ST_MUL_CG_LO;
            ST_MUL_CG_LO: state_next = ST_MUL_CG_HI;
            ST_MUL_CG_HI: state_next = ST_CG_SUM;
            ST_CG_SUM:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_BASS;
        cmd.acc_op   = ACC_HOLD;
        in_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_MUL_BASS:
            begin
                cmd.mul_sel = MUL_BASS;
            end
            ST_MUL_TREB:
            begin
                cmd.mul_sel  = MUL_TREB;
                cmd.upd_bass = 1'b1;
            end
            ST_MUL_LOW:
            begin
                cmd.mul_sel  = MUL_LOW;
                cmd.upd_treb = 1'b1;
            end
            ST_MUL_MID:
            begin
                cmd.mul_sel = MUL_MID;
                cmd.acc_op  = ACC_LOAD_BAND;
            end
            ST_MUL_HIGH:
            begin
                cmd.mul_sel = MUL_HIGH;
                cmd.acc_op  = ACC_ADD;
            end
            ST_SUM:
            begin
                cmd.acc_op = ACC_ADD;
            end
            ST_MUL_CG_LO:
            begin
                cmd.mul_sel = MUL_CG_LO;
            end
            ST_MUL_CG_HI:
            begin
                cmd.mul_sel = MUL_CG_HI;
                cmd.acc_op  = ACC_LOAD_CHAN;
            end
            ST_CG_SUM:
            begin
                cmd.acc_op = ACC_ADD_HIGH;
            end
            ST_FINISH:
            begin
                cmd.load_out = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/tbeq_datapath.sv -----
// equalizer datapath: config registers, per-channel filter state, shared multiplier,
// accumulator and output word register; depends on tbeq_pkg

module tbeq_datapath #(
    parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tbeq_pkg::dp_cmd_t                     cmd,
    output tbeq_pkg::dp_status_t                  status,
    input  logic signed [tbeq_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [tbeq_pkg::CHAN_W-1:0]           chan_index,
    input  logic                                  block_end,
    input  logic                                  cfg_write,
    input  logic [tbeq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbeq_pkg::CFG_W-1:0]            cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [tbeq_pkg::SAMPLE_W-1:0]  sample_out,
    output logic [tbeq_pkg::CHAN_W-1:0]           chan_out,
    output logic                                  block_end_out
);
    import tbeq_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RES_W = ACC_W - CHAN_SHIFT;
    localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
    localparam logic signed [ACC_W-1:0] BAND_BIAS = ACC_W'(64'sd1 <<< (BAND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] CHAN_BIAS = ACC_W'(64'sd1 <<< (CHAN_SHIFT - 1));
    localparam logic [FILT_SHIFT-1:0]   FILT_HALF = FILT_SHIFT'(1 << (FILT_SHIFT - 1));

    // configuration registers
    logic [COEF_W-1:0] bass_coef_reg;
    logic [COEF_W-1:0] treble_coef_reg;
    logic [GAIN_W-1:0] bass_gain_reg;
    logic [GAIN_W-1:0] mid_gain_reg;
    logic [GAIN_W-1:0] treble_gain_reg;
    logic [CFG_W-1:0]  chan_lower_reg;
    logic [CFG_W-1:0]  chan_upper_reg;

    // input word and per-channel filter state
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CHAN_W-1:0]          ch_reg;
    logic                       be_reg;
    logic                       bypass_reg;
    logic signed [STATE_W-1:0]  bass_lp_reg [NUM_CHANNELS];
    logic signed [STATE_W-1:0]  treb_lp_reg [NUM_CHANNELS];
    logic signed [STATE_W-1:0]  low_reg;
    logic signed [STATE_W-1:0]  tlp_reg;

    // arithmetic
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [OPA_W-1:0]    op_a;
    logic [GAIN_W-1:0]          op_b_raw;
    logic signed [OPB_W-1:0]    op_b;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [STATE_W-1:0]  x31;
    logic [IDX_W-1:0]           idx;
    logic signed [PROD_W-1:0]   filt_sum;
    logic signed [STATE_W-1:0]  filt_y;
    logic signed [ACC_W-1:0]    prod_ext;
    logic [CFG_W-1:0]           gain_word;
    logic [GAIN_W-1:0]          chan_gain;
    logic signed [RES_W-1:0]    res_full;
    logic signed [SAMPLE_W-1:0] res_sat;

    // output word register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_W-1:0]          chan_out_reg;
    logic                       be_out_reg;

    assign x31 = {x_reg, 8'b0};
    assign idx = ch_reg[IDX_W-1:0];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_coef_reg   <= BASS_COEF_RST;
            treble_coef_reg <= TREBLE_COEF_RST;
            bass_gain_reg   <= UNITY_GAIN_RST;
            mid_gain_reg    <= UNITY_GAIN_RST;
            treble_gain_reg <= UNITY_GAIN_RST;
            chan_lower_reg  <= CHAN_GAINS_RST;
            chan_upper_reg  <= CHAN_GAINS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASS_COEF:   bass_coef_reg   <= cfg_data[COEF_W-1:0];
                REG_TREBLE_COEF: treble_coef_reg <= cfg_data[COEF_W-1:0];
                REG_BASS_GAIN:   bass_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_MID_GAIN:    mid_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_TREBLE_GAIN: treble_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_CHAN_LOWER:  chan_lower_reg  <= cfg_data;
                REG_CHAN_UPPER:  chan_upper_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // capture input word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg      <= sample_in;
            ch_reg     <= chan_index;
            be_reg     <= block_end;
            bypass_reg <= (int'(chan_index) >= NUM_CHANNELS);
        end
    end

    // multiplier operands
    always_comb
    begin
        op_a     = '0;
        op_b_raw = '0;
        case (cmd.mul_sel)
            MUL_BASS:
            begin
                op_a     = OPA_W'(bass_lp_reg[idx]) - OPA_W'(x31);
                op_b_raw = bass_coef_reg;
            end
            MUL_TREB:
            begin
                op_a     = OPA_W'(treb_lp_reg[idx]) - OPA_W'(x31);
                op_b_raw = treble_coef_reg;
            end
            MUL_LOW:
            begin
                op_a     = OPA_W'(low_reg);
                op_b_raw = bass_gain_reg;
            end
            MUL_MID:
            begin
                op_a     = OPA_W'(tlp_reg) - OPA_W'(low_reg);
                op_b_raw = mid_gain_reg;
            end
            MUL_HIGH:
            begin
                op_a     = OPA_W'(x31) - OPA_W'(tlp_reg);
                op_b_raw = treble_gain_reg;
            end
            MUL_CG_LO:
            begin
                op_a     = $signed({{(OPA_W-HI_SPLIT){1'b0}},
                                    acc_reg[BAND_SHIFT+HI_SPLIT-1:BAND_SHIFT]});
                op_b_raw = chan_gain;
            end
            MUL_CG_HI:
            begin
                op_a     = OPA_W'($signed(acc_reg[ACC_W-7:BAND_SHIFT+HI_SPLIT]));
                op_b_raw = chan_gain;
            end
            default:
            begin
                op_a     = '0;
                op_b_raw = '0;
            end
        endcase
    end

    // channel gain select, four gains per register
    assign gain_word = ch_reg[CHAN_W-1] ? chan_upper_reg : chan_lower_reg;
    assign chan_gain = gain_word[GAIN_W*ch_reg[1:0] +: GAIN_W];

    assign op_b     = $signed({1'b0, op_b_raw});
    assign mul_prod = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
    end

    // filter output: x31 + round(c * (state - x31) / 2^16)
    assign filt_sum = PROD_W'($signed({x31, FILT_HALF})) + prod_reg;
    assign filt_y   = filt_sum[FILT_SHIFT+STATE_W-1:FILT_SHIFT];

    always_ff @(posedge clk)
    begin
        if (cmd.upd_bass)
        begin
            low_reg <= filt_y;
        end
        if (cmd.upd_treb)
        begin
            tlp_reg <= filt_y;
        end
    end

    // per-channel filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                bass_lp_reg[i] <= '0;
                treb_lp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.upd_bass && !bypass_reg)
            begin
                bass_lp_reg[idx] <= filt_y;
            end
            if (cmd.upd_treb && !bypass_reg)
            begin
                treb_lp_reg[idx] <= filt_y;
            end
        end
    end

    // accumulator, rounding bias folded in at load
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            ACC_HOLD:      acc_next = acc_reg;
            ACC_LOAD_BAND: acc_next = prod_ext + BAND_BIAS;
            ACC_ADD:       acc_next = acc_reg + prod_ext;
            ACC_LOAD_CHAN: acc_next = prod_ext + CHAN_BIAS;
            ACC_ADD_HIGH:  acc_next = acc_reg + (prod_ext <<< HI_SPLIT);
            default:       acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // final shift and saturation
    assign res_full = acc_reg[ACC_W-1:CHAN_SHIFT];

    always_comb
    begin
        if (res_full > SAT_MAX)
        begin
            res_sat = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (res_full < SAT_MIN)
        begin
            res_sat = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            res_sat = res_full[SAMPLE_W-1:0];
        end
    end

    // output word register
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_out_reg <= bypass_reg ? x_reg : res_sat;
            chan_out_reg   <= ch_reg;
            be_out_reg     <= be_reg;
        end
    end

    assign status.bypass   = bypass_reg;
    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign chan_out      = chan_out_reg;
    assign block_end_out = be_out_reg;

endmodule

// ----- sv/three_band_equalizer_unit.sv -----
// top level of the three-band equalizer: sequencer plus datapath
// depends on tbeq_pkg, tbeq_ctrl and tbeq_datapath
//
//   channel  | signals                                          | direction
//   ---------+--------------------------------------------------+----------
//   input    | in_valid, in_stall, sample_in, chan_index,       | in
//            | block_end                                        |
//   output   | out_valid, out_stall, sample_out, chan_out,      | out
//            | block_end_out                                    |
//   config   | cfg_write, cfg_index, cfg_data                   | in
//
// a word runs every step between accepts if its channel is configured, and skips from
// the bass step to finish if passed through; the seven products of the
// filters, band weights and channel gain share one 33x17 multiplier, one per cycle.
// reset clears the filter state of all channels at once and loads the register defaults.
// a finished word waits in the output register; the next word is taken meanwhile and
// holds in its last step only if the output register is still full.

module three_band_equalizer_unit #(
    parameter int NUM_CHANNELS = tbeq_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tbeq_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic [tbeq_pkg::CHAN_W-1:0]           chan_index,
    input  logic                                  block_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [tbeq_pkg::SAMPLE_W-1:0]  sample_out,
    output logic [tbeq_pkg::CHAN_W-1:0]           chan_out,
    output logic                                  block_end_out,
    input  logic                                  cfg_write,
    input  logic [tbeq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbeq_pkg::CFG_W-1:0]            cfg_data
);
    import tbeq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    tbeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    tbeq_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_in     (sample_in),
        .chan_index    (chan_index),
        .block_end     (block_end),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .chan_out      (chan_out),
        .block_end_out (block_end_out)
    );

endmodule

// ----- sv/tbeq_checker.sv -----
// port-level checks of the three-band equalizer, bound to the top level
// depends on tbeq_pkg and three_band_equalizer_unit

module tbeq_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [tbeq_pkg::SAMPLE_W-1:0]  sample_out,
    input logic [tbeq_pkg::CHAN_W-1:0]           chan_out,
    input logic                                  block_end_out
);
    import tbeq_pkg::*;

    logic in_take;
    assign in_take = in_valid && !in_stall;

    // a held output word keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out)
            && $stable(chan_out) && $stable(block_end_out))
        else $error("output word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input taken again right after an accept");

    // a new output word only comes out of a busy sequencer
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output word appeared without work in progress");

    // no result can be ready in the cycle right after its word was taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !$rose(out_valid))
        else $error("output word appeared too early");

endmodule

bind three_band_equalizer_unit tbeq_checker u_tbeq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .chan_out      (chan_out),
    .block_end_out (block_end_out)
);
